// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by sogi_quadrature_filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication checked on the cycle after the trigger.
`define ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/sogi_qf_pkg.sv =====
// ----------------------------------------------------------------------------
// sogi_qf_pkg
// Widths, register map and arithmetic helpers of the SOGI quadrature filter.
// ----------------------------------------------------------------------------
package sogi_qf_pkg;

    // Datapath widths
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    // Five products of at most 2^62 each: 67 bits hold the exact sum
    localparam int ACC_W     = PROD_W + 3;
    localparam int OUT_W     = 25;
    localparam int SHIFT_W   = 5;
    localparam int GAIN_SHIFT = 7;

    // APB register map
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [OUT_W-1:0] out_t;

    localparam reg_idx_t REG_B0    = 3'd0;
    localparam reg_idx_t REG_B2    = 3'd1;
    localparam reg_idx_t REG_A1    = 3'd2;
    localparam reg_idx_t REG_A2    = 3'd3;
    localparam reg_idx_t REG_Q0    = 3'd4;
    localparam reg_idx_t REG_Q1    = 3'd5;
    localparam reg_idx_t REG_Q2    = 3'd6;
    localparam reg_idx_t REG_SHIFT = 3'd7;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Clamp a wide sum to the signed 32-bit range
    function automatic data_t sat_acc(input acc_t v);
        logic [ACC_W-DATA_W:0] top;
        top = v[ACC_W-1:DATA_W-1];
        if ((&top) || !(|top))
            return v[DATA_W-1:0];
        else
            return v[ACC_W-1] ? DATA_MIN : DATA_MAX;
    endfunction

    // Divide by 128, rounding toward zero
    function automatic out_t div_gain(input data_t v);
        data_t q;
        q = v >>> GAIN_SHIFT;
        if (v[DATA_W-1] && (|v[GAIN_SHIFT-1:0]))
            q = q + data_t'(1);
        return q[OUT_W-1:0];
    endfunction

    // Sample minus filter output, clamped to 32 bits
    function automatic data_t err_sat(input data_t x, input out_t u);
        logic signed [DATA_W:0] d;
        d = (DATA_W+1)'(x) - (DATA_W+1)'(u);
        if (d[DATA_W] != d[DATA_W-1])
            return d[DATA_W] ? DATA_MIN : DATA_MAX;
        else
            return d[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/sogi_quadrature_filter.sv =====
// ----------------------------------------------------------------------------
// sogi_quadrature_filter
// Second-order generalized integrator: in-phase and quadrature IIR sections.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while the result side does not stall
// and returns one request per sample. A sample lands in an input register;
// the nine 32x32 products, the two wide sums, the shift by frac_shift, the
// clamp to 32 bits and the division by 128 then run combinationally into the
// result register, which holds the result until the output side is ready and
// also updates the sample and output histories. That path, closed through the
// a1/a2 feedback on the last outputs, sets the clock rate. The user must write
// coefficients over the APB port while idle; the block does not enforce it.
`include "assert_macros.svh"

module sogi_quadrature_filter #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample channel
    input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    // Result channel
    output logic signed [sogi_qf_pkg::OUT_W-1:0]  in_phase,
    output logic signed [sogi_qf_pkg::OUT_W-1:0]  quadrature,
    output logic signed [sogi_qf_pkg::DATA_W-1:0] error_out,
    output logic                                result_valid,
    input  logic                                result_ready,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sogi_qf_pkg::PADDR_W-1:0]     paddr,
    input  logic [sogi_qf_pkg::DATA_W-1:0]      pwdata,
    output logic [sogi_qf_pkg::DATA_W-1:0]      prdata,
    output logic                                pready
);

    // Configuration registers
    sogi_qf_pkg::data_t coef_b0_reg, coef_b2_reg, coef_a1_reg, coef_a2_reg;
    sogi_qf_pkg::data_t coef_q0_reg, coef_q1_reg, coef_q2_reg;
    logic [sogi_qf_pkg::SHIFT_W-1:0] frac_shift_reg;

    // Filter history
    sogi_qf_pkg::data_t sample_d1_reg, sample_d2_reg;
    sogi_qf_pkg::data_t inphase_acc_d1_reg, inphase_acc_d2_reg;
    sogi_qf_pkg::data_t quad_acc_d1_reg, quad_acc_d2_reg;

    // Input stage and result stage
    logic               stg_valid_reg;
    sogi_qf_pkg::data_t stg_sample_reg;
    logic               res_valid_reg;
    sogi_qf_pkg::out_t  in_phase_reg, quadrature_reg;
    sogi_qf_pkg::data_t error_out_reg;

    logic                      cfg_wr;
    sogi_qf_pkg::reg_idx_t     cfg_idx;
    logic                      res_adv;
    logic                      stg_fire;
    logic                      sample_fire;
    logic signed [SAMPLE_WIDTH-1:0] sample_s;
    sogi_qf_pkg::data_t        sample_ext;

    logic signed [sogi_qf_pkg::PROD_W-1:0] p_b0, p_b2, p_a1y, p_a2y;
    logic signed [sogi_qf_pkg::PROD_W-1:0] p_q0, p_q1, p_q2, p_a1q, p_a2q;
    sogi_qf_pkg::acc_t  sum_i, sum_q, shr_i, shr_q;
    sogi_qf_pkg::data_t y0, qy0;
    sogi_qf_pkg::out_t  u0, qu0;
    sogi_qf_pkg::data_t err0;

    // Handshake
    assign res_adv      = !res_valid_reg || result_ready;
    assign stg_fire     = stg_valid_reg && res_adv;
    assign sample_ready = !stg_valid_reg || res_adv;
    assign sample_fire  = sample_valid && sample_ready;

    // Sign-extend the sample to the datapath width
    assign sample_s   = sample_in;
    assign sample_ext = sogi_qf_pkg::DATA_W'(sample_s);

    // APB decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[sogi_qf_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg    <= '0;
            coef_b2_reg    <= '0;
            coef_a1_reg    <= '0;
            coef_a2_reg    <= '0;
            coef_q0_reg    <= '0;
            coef_q1_reg    <= '0;
            coef_q2_reg    <= '0;
            frac_shift_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                sogi_qf_pkg::REG_B0:    coef_b0_reg <= pwdata;
                sogi_qf_pkg::REG_B2:    coef_b2_reg <= pwdata;
                sogi_qf_pkg::REG_A1:    coef_a1_reg <= pwdata;
                sogi_qf_pkg::REG_A2:    coef_a2_reg <= pwdata;
                sogi_qf_pkg::REG_Q0:    coef_q0_reg <= pwdata;
                sogi_qf_pkg::REG_Q1:    coef_q1_reg <= pwdata;
                sogi_qf_pkg::REG_Q2:    coef_q2_reg <= pwdata;
                sogi_qf_pkg::REG_SHIFT: frac_shift_reg <= pwdata[sogi_qf_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (cfg_idx)
            sogi_qf_pkg::REG_B0:    prdata = coef_b0_reg;
            sogi_qf_pkg::REG_B2:    prdata = coef_b2_reg;
            sogi_qf_pkg::REG_A1:    prdata = coef_a1_reg;
            sogi_qf_pkg::REG_A2:    prdata = coef_a2_reg;
            sogi_qf_pkg::REG_Q0:    prdata = coef_q0_reg;
            sogi_qf_pkg::REG_Q1:    prdata = coef_q1_reg;
            sogi_qf_pkg::REG_Q2:    prdata = coef_q2_reg;
            sogi_qf_pkg::REG_SHIFT: prdata = sogi_qf_pkg::DATA_W'(frac_shift_reg);
            default:                prdata = '0;
        endcase
    end

    // Products; the in-phase section has no term on x1
    assign p_b0  = coef_b0_reg * stg_sample_reg;
    assign p_b2  = coef_b2_reg * sample_d2_reg;
    assign p_a1y = coef_a1_reg * inphase_acc_d1_reg;
    assign p_a2y = coef_a2_reg * inphase_acc_d2_reg;
    assign p_q0  = coef_q0_reg * stg_sample_reg;
    assign p_q1  = coef_q1_reg * sample_d1_reg;
    assign p_q2  = coef_q2_reg * sample_d2_reg;
    assign p_a1q = coef_a1_reg * quad_acc_d1_reg;
    assign p_a2q = coef_a2_reg * quad_acc_d2_reg;

    // Exact sums, shift, clamp
    assign sum_i = sogi_qf_pkg::ACC_W'(p_b0) + sogi_qf_pkg::ACC_W'(p_b2)
                 - sogi_qf_pkg::ACC_W'(p_a1y) - sogi_qf_pkg::ACC_W'(p_a2y);
    assign sum_q = sogi_qf_pkg::ACC_W'(p_q0) + sogi_qf_pkg::ACC_W'(p_q1)
                 + sogi_qf_pkg::ACC_W'(p_q2)
                 - sogi_qf_pkg::ACC_W'(p_a1q) - sogi_qf_pkg::ACC_W'(p_a2q);
    assign shr_i = sum_i >>> frac_shift_reg;
    assign shr_q = sum_q >>> frac_shift_reg;
    assign y0    = sogi_qf_pkg::sat_acc(shr_i);
    assign qy0   = sogi_qf_pkg::sat_acc(shr_q);

    // Output scaling and error term
    assign u0   = sogi_qf_pkg::div_gain(y0);
    assign qu0  = sogi_qf_pkg::div_gain(qy0);
    assign err0 = sogi_qf_pkg::err_sat(stg_sample_reg, u0);

    // Pipeline control and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg      <= 1'b0;
            res_valid_reg      <= 1'b0;
            sample_d1_reg      <= '0;
            sample_d2_reg      <= '0;
            inphase_acc_d1_reg <= '0;
            inphase_acc_d2_reg <= '0;
            quad_acc_d1_reg    <= '0;
            quad_acc_d2_reg    <= '0;
        end
        else
        begin
            stg_valid_reg <= sample_fire || (stg_valid_reg && !res_adv);
            if (res_adv)
                res_valid_reg <= stg_valid_reg;
            if (stg_fire)
            begin
                sample_d2_reg      <= sample_d1_reg;
                sample_d1_reg      <= stg_sample_reg;
                inphase_acc_d2_reg <= inphase_acc_d1_reg;
                inphase_acc_d1_reg <= y0;
                quad_acc_d2_reg    <= quad_acc_d1_reg;
                quad_acc_d1_reg    <= qy0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (sample_fire)
            stg_sample_reg <= sample_ext;
        if (stg_fire)
        begin
            in_phase_reg   <= u0;
            quadrature_reg <= qu0;
            error_out_reg  <= err0;
        end
    end

    assign result_valid = res_valid_reg;
    assign in_phase     = in_phase_reg;
    assign quadrature   = quadrature_reg;
    assign error_out    = error_out_reg;

    // Checks
    `ASSERT_NEXT(a_stage_to_result, stg_fire, res_valid_reg,
        "item left input stage but no result is pending")
    `ASSERT_NEXT(a_history_shift, stg_fire,
        sample_d2_reg == $past(sample_d1_reg) && inphase_acc_d2_reg == $past(inphase_acc_d1_reg)
        && quad_acc_d2_reg == $past(quad_acc_d1_reg),
        "history did not shift by one item")
    `ASSERT_NEXT(a_history_hold, !stg_fire,
        $stable(sample_d1_reg) && $stable(inphase_acc_d1_reg) && $stable(quad_acc_d1_reg),
        "history changed without an item")
    `ASSERT_CLK(a_full_stage_ready, (stg_valid_reg && res_adv) |-> sample_ready,
        "input stall while the stage drains")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SOGI quadrature filter. Samples go in over a
// valid/ready channel and each result request is checked against a
// bit-exact prediction of both IIR sections. Coefficients are loaded over
// APB between phases, with varied idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int OUT_GAIN       = 1 << sogi_qf_pkg::GAIN_SHIFT;
    localparam int SHIFT_MAX      = (1 << sogi_qf_pkg::SHIFT_W) - 1;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        sogi_qf_pkg::out_t  in_phase;
        sogi_qf_pkg::out_t  quadrature;
        sogi_qf_pkg::data_t err_sample;
    } filter_result_t;

    typedef enum logic {FILTER_STABLE, FILTER_WILD} filter_kind_t;

    // Predicts filter outputs per accepted sample and checks result requests
    class sogi_tracker;
        sogi_qf_pkg::data_t b0, b2, a1, a2, q0, q1, q2;
        logic [sogi_qf_pkg::SHIFT_W-1:0] shift;
        sogi_qf_pkg::data_t x_d1, x_d2, y_d1, y_d2, qy_d1, qy_d2;
        filter_result_t expected_q[$];
        int mismatches;

        function new();
            b0 = 0; b2 = 0; a1 = 0; a2 = 0; q0 = 0; q1 = 0; q2 = 0;
            shift = 0;
            x_d1 = 0; x_d2 = 0; y_d1 = 0; y_d2 = 0; qy_d1 = 0; qy_d2 = 0;
            mismatches = 0;
        endfunction

        function void set_register(sogi_qf_pkg::reg_idx_t idx,
                                   logic [sogi_qf_pkg::DATA_W-1:0] value);
            case (idx)
                sogi_qf_pkg::REG_B0:    b0 = value;
                sogi_qf_pkg::REG_B2:    b2 = value;
                sogi_qf_pkg::REG_A1:    a1 = value;
                sogi_qf_pkg::REG_A2:    a2 = value;
                sogi_qf_pkg::REG_Q0:    q0 = value;
                sogi_qf_pkg::REG_Q1:    q1 = value;
                sogi_qf_pkg::REG_Q2:    q2 = value;
                sogi_qf_pkg::REG_SHIFT: shift = value[sogi_qf_pkg::SHIFT_W-1:0];
                default:   ;
            endcase
        endfunction

        function wide_t product(sogi_qf_pkg::data_t c, sogi_qf_pkg::data_t v);
            longint p;
            wide_t w;
            p = longint'(c) * longint'(v);
            w = p;
            return w;
        endfunction

        function sogi_qf_pkg::data_t clamp_wide(wide_t v);
            wide_t hi;
            wide_t lo;
            hi = sogi_qf_pkg::DATA_MAX;
            lo = sogi_qf_pkg::DATA_MIN;
            if (v > hi)
                return sogi_qf_pkg::DATA_MAX;
            if (v < lo)
                return sogi_qf_pkg::DATA_MIN;
            return v[sogi_qf_pkg::DATA_W-1:0];
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction

        // Run both sections for one sample, queue the result, shift histories
        function void add_sample(sogi_qf_pkg::data_t x0);
            wide_t s;
            wide_t q;
            sogi_qf_pkg::data_t y0;
            sogi_qf_pkg::data_t qy0;
            int u;
            int qu;
            longint d;
            filter_result_t r;
            s = product(b0, x0) + product(b2, x_d2)
                - product(a1, y_d1) - product(a2, y_d2);
            q = product(q0, x0) + product(q1, x_d1) + product(q2, x_d2)
                - product(a1, qy_d1) - product(a2, qy_d2);
            s = s >>> shift;
            q = q >>> shift;
            y0  = clamp_wide(s);
            qy0 = clamp_wide(q);
            // integer division truncates toward zero
            u  = y0 / OUT_GAIN;
            qu = qy0 / OUT_GAIN;
            d  = longint'(x0) - longint'(u);
            r.in_phase   = u[sogi_qf_pkg::OUT_W-1:0];
            r.quadrature = qu[sogi_qf_pkg::OUT_W-1:0];
            r.err_sample = clamp_wide(d);
            expected_q.push_back(r);
            x_d2  = x_d1;  x_d1  = x0;
            y_d2  = y_d1;  y_d1  = y0;
            qy_d2 = qy_d1; qy_d1 = qy0;
        endfunction

        function void check_output(sogi_qf_pkg::out_t ip, sogi_qf_pkg::out_t qd,
                                   sogi_qf_pkg::data_t er);
            filter_result_t e;
            if (expected_q.size() == 0)
            begin
                $error("result with no sample pending: in_phase %0d", ip);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (ip !== e.in_phase)
            begin
                $error("in_phase: expected %0d, actual %0d", $signed(e.in_phase), ip);
                mismatches++;
            end
            if (qd !== e.quadrature)
            begin
                $error("quadrature: expected %0d, actual %0d",
                       $signed(e.quadrature), qd);
                mismatches++;
            end
            if (er !== e.err_sample)
            begin
                $error("error_out: expected %0d, actual %0d",
                       $signed(e.err_sample), er);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    sogi_qf_pkg::data_t sample_in;
    logic        sample_valid;
    logic        sample_ready;
    sogi_qf_pkg::out_t  in_phase;
    sogi_qf_pkg::out_t  quadrature;
    sogi_qf_pkg::data_t error_out;
    logic        result_valid;
    logic        result_ready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [sogi_qf_pkg::PADDR_W-1:0] paddr;
    logic [sogi_qf_pkg::DATA_W-1:0]  pwdata;
    logic [sogi_qf_pkg::DATA_W-1:0]  prdata;
    logic        pready;

    sogi_tracker tracker;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_request;
    int          hold_left;
    int          stall_cycles;

    sogi_quadrature_filter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_in    (sample_in),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .in_phase     (in_phase),
        .quadrature   (quadrature),
        .error_out    (error_out),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one sample, with random idle cycles ahead of it
    task automatic send_sample(input sogi_qf_pkg::data_t x);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample_in    = x;
        sample_valid = 1'b1;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        tracker.add_sample(x);
    endtask

    // Stop offering and let every pending result drain out
    task automatic wait_idle();
        @(negedge clk);
        sample_valid = 1'b0;
        while (tracker.pending_count() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic apb_write(input sogi_qf_pkg::reg_idx_t idx,
                             input logic [sogi_qf_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        tracker.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_filter(input sogi_qf_pkg::data_t b0, input sogi_qf_pkg::data_t b2,
                                input sogi_qf_pkg::data_t a1, input sogi_qf_pkg::data_t a2,
                                input sogi_qf_pkg::data_t q0, input sogi_qf_pkg::data_t q1,
                                input sogi_qf_pkg::data_t q2, input int sh);
        wait_idle();
        apb_write(sogi_qf_pkg::REG_B0, b0);
        apb_write(sogi_qf_pkg::REG_B2, b2);
        apb_write(sogi_qf_pkg::REG_A1, a1);
        apb_write(sogi_qf_pkg::REG_A2, a2);
        apb_write(sogi_qf_pkg::REG_Q0, q0);
        apb_write(sogi_qf_pkg::REG_Q1, q1);
        apb_write(sogi_qf_pkg::REG_Q2, q2);
        apb_write(sogi_qf_pkg::REG_SHIFT, sh);
    endtask

    function automatic int rand_sym(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    // Stable: poles inside the unit circle, so histories stay meaningful; wild: all random
    task automatic load_random_filter(input filter_kind_t kind);
        int sh;
        int unit;
        int a2v;
        int bound;
        int scale;
        int b0v;
        if (kind == FILTER_WILD)
        begin
            write_filter($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom_range(0, SHIFT_MAX));
        end
        else
        begin
            sh    = $urandom_range(12, 24);
            unit  = 1 << sh;
            a2v   = (unit / 16) * int'($urandom_range(4, 15));
            bound = unit + a2v - unit / 8;
            scale = unit / 4;
            b0v   = rand_sym(scale);
            write_filter(b0v, -b0v, rand_sym(bound), a2v, rand_sym(scale),
                         rand_sym(scale), rand_sym(scale), sh);
        end
    endtask

    // Mostly moderate sign-extended values, some full range and rails
    function automatic sogi_qf_pkg::data_t random_sample();
        int pick;
        int w;
        sogi_qf_pkg::data_t v;
        pick = $urandom_range(99);
        if (pick < 4)
            v = sogi_qf_pkg::DATA_MAX;
        else if (pick < 8)
            v = sogi_qf_pkg::DATA_MIN;
        else if (pick < 20)
            v = $urandom;
        else
        begin
            w = $urandom_range(4, 24);
            v = $urandom;
            v = v >>> (sogi_qf_pkg::DATA_W - w);
        end
        return v;
    endfunction

    // Result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready = 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                result_ready = 1'b0;
            end
            else
                result_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every accepted result request
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            tracker.check_output(in_phase, quadrature, error_out);
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
            (psel && penable && pwrite && pready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        int regime;
        tracker       = new();
        rst_n         = 1'b0;
        sample_in     = '0;
        sample_valid  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_request  = 1'b0;
        stall_cycles  = 0;
        send_idle_pct = 28;
        recv_idle_pct = 80;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        for (regime = 0; regime < 3; regime++)
        begin
            send_idle_pct = (regime == 0) ? 28 : (regime == 1) ? 80 : 0;
            recv_idle_pct = (regime == 0) ? 80 : (regime == 1) ? 28 : 0;

            if (regime == 0)
            begin
                // Reset coefficients: outputs zero, error follows the sample
                send_sample(0);
                send_sample(sogi_qf_pkg::DATA_MAX);
                send_sample(sogi_qf_pkg::DATA_MIN);
                send_sample(-1);

                // Extreme coefficients with no shift: heavy saturation
                write_filter(-1, sogi_qf_pkg::DATA_MIN, sogi_qf_pkg::DATA_MAX,
                             sogi_qf_pkg::DATA_MIN, sogi_qf_pkg::DATA_MIN,
                             sogi_qf_pkg::DATA_MAX, -1, 0);
                send_sample(sogi_qf_pkg::DATA_MIN);
                send_sample(sogi_qf_pkg::DATA_MAX);
                send_sample(sogi_qf_pkg::DATA_MIN);
                send_sample(1);
                send_sample(-1);
                send_sample(0);
                send_sample(sogi_qf_pkg::DATA_MAX);
                send_sample(sogi_qf_pkg::DATA_MAX);

                // Largest shift on the exact wide sum
                write_filter(sogi_qf_pkg::DATA_MAX, sogi_qf_pkg::DATA_MIN,
                             sogi_qf_pkg::DATA_MIN, sogi_qf_pkg::DATA_MAX,
                             sogi_qf_pkg::DATA_MAX, sogi_qf_pkg::DATA_MIN,
                             sogi_qf_pkg::DATA_MAX, SHIFT_MAX);
                send_sample(sogi_qf_pkg::DATA_MAX);
                send_sample(sogi_qf_pkg::DATA_MIN);
                send_sample(sogi_qf_pkg::DATA_MAX);
                send_sample(sogi_qf_pkg::DATA_MIN);
                send_sample(12345);

                // Shift just below the top
                write_filter(sogi_qf_pkg::DATA_MIN, sogi_qf_pkg::DATA_MAX, 0, 0,
                             sogi_qf_pkg::DATA_MIN, sogi_qf_pkg::DATA_MIN,
                             sogi_qf_pkg::DATA_MIN, SHIFT_MAX - 1);
                send_sample(sogi_qf_pkg::DATA_MIN);
                send_sample(sogi_qf_pkg::DATA_MIN);
                send_sample(sogi_qf_pkg::DATA_MAX);

                // Negated input: error output clamps at both rails
                write_filter(-1, 0, 0, 0, 0, 0, 0, 0);
                send_sample(sogi_qf_pkg::DATA_MIN);
                send_sample(sogi_qf_pkg::DATA_MAX);
            end

            load_random_filter(FILTER_STABLE);
            if (regime == 2)
            begin
                // long receiver hold-off while samples keep coming
                @(posedge clk);
                hold_request = 1'b1;
            end
            repeat (100) send_sample(random_sample());
            load_random_filter(FILTER_WILD);
            repeat (30) send_sample(random_sample());
            load_random_filter(FILTER_STABLE);
            repeat (100) send_sample(random_sample());
        end

        wait_idle();
        if (tracker.mismatches == 0 && tracker.pending_count() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
